/* rtl/rmq_pkg.sv */
// Shared types and constants for the rotation matrix to quaternion block.
package rmq_pkg;

	// Entry and component width (signed fixed point)
	localparam int ENTRY_W = 16;
	// Magnitude of a sum or difference of two entries
	localparam int MAG_W   = ENTRY_W + 1;
	// Quotient bits kept by the divider (anything above saturates)
	localparam int QB      = 17;
	// Off-diagonal lanes (three components besides the chosen one)
	localparam int LANES   = 3;

	localparam logic signed [ENTRY_W-1:0] COMP_MAX = 16'sh7FFF;
	localparam logic signed [ENTRY_W-1:0] COMP_MIN = 16'sh8000;

	typedef logic signed [ENTRY_W-1:0] entry_t;

	// Chosen branch code
	typedef enum logic [1:0] {
		TERM_W = 2'd0,
		TERM_X = 2'd1,
		TERM_Y = 2'd2,
		TERM_Z = 2'd3
	} term_t;

endpackage

/* rtl/rmq_in_if.sv */
// Matrix input channel: valid/ready handshake and the nine matrix entries.
interface rmq_in_if import rmq_pkg::*; ();
	logic   valid;
	logic   ready;
	entry_t m_0_0;
	entry_t m_0_1;
	entry_t m_0_2;
	entry_t m_1_0;
	entry_t m_1_1;
	entry_t m_1_2;
	entry_t m_2_0;
	entry_t m_2_1;
	entry_t m_2_2;

	modport source (output valid, m_0_0, m_0_1, m_0_2, m_1_0, m_1_1, m_1_2,
		m_2_0, m_2_1, m_2_2, input ready);
	modport sink (input valid, m_0_0, m_0_1, m_0_2, m_1_0, m_1_1, m_1_2,
		m_2_0, m_2_1, m_2_2, output ready);
endinterface

/* rtl/rmq_out_if.sv */
// Quaternion output channel: valid/ready handshake and the result word.
interface rmq_out_if import rmq_pkg::*; ();
	logic        valid;
	logic        ready;
	entry_t      quat_w;
	entry_t      quat_x;
	entry_t      quat_y;
	entry_t      quat_z;
	logic [1:0]  largest_term;
	logic        not_rotation;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, largest_term,
		not_rotation, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, largest_term,
		not_rotation, output ready);
endinterface

/* rtl/rmq_front.sv */
// First stage: candidate terms, branch pick, root argument and off-diagonal lanes.
module rmq_front import rmq_pkg::*; #(
	parameter int FRAC_BITS = 14,
	parameter int AW        = 19
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  entry_t               m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic                 vld_s1,
	output term_t                sel_s1,
	output logic                 bad_s1,
	output logic [AW-2:0]        arg_s1,
	output logic [LANES-1:0]     neg_s1,
	output logic [MAG_W-1:0]     mag_s1 [LANES]
);

	localparam logic [AW-1:0] ARG_ONE = AW'(1) << FRAC_BITS;

	logic signed [17:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [17:0] t0, t1, t2, t3, big;
	logic signed [AW-1:0] arg;
	logic signed [17:0] d [LANES];
	term_t sel;

	assign e00 = 18'(m00);
	assign e01 = 18'(m01);
	assign e02 = 18'(m02);
	assign e10 = 18'(m10);
	assign e11 = 18'(m11);
	assign e12 = 18'(m12);
	assign e20 = 18'(m20);
	assign e21 = 18'(m21);
	assign e22 = 18'(m22);

	// Candidate terms and largest pick, ties to the earlier term
	always_comb begin
		t0 = e00 + e11 + e22;
		t1 = e00 - e11 - e22;
		t2 = e11 - e00 - e22;
		t3 = e22 - e00 - e11;
		big = t0;
		sel = TERM_W;
		if (t1 > big) begin
			big = t1;
			sel = TERM_X;
		end
		if (t2 > big) begin
			big = t2;
			sel = TERM_Y;
		end
		if (t3 > big) begin
			big = t3;
			sel = TERM_Z;
		end
	end

	assign arg = AW'(big) + $signed(ARG_ONE);

	// Off-diagonal sums/differences in output order, chosen slot skipped
	always_comb begin
		case (sel)
			TERM_W: begin
				d[0] = e12 - e21;
				d[1] = e20 - e02;
				d[2] = e01 - e10;
			end
			TERM_X: begin
				d[0] = e12 - e21;
				d[1] = e01 + e10;
				d[2] = e20 + e02;
			end
			TERM_Y: begin
				d[0] = e20 - e02;
				d[1] = e01 + e10;
				d[2] = e12 + e21;
			end
			default: begin
				d[0] = e01 - e10;
				d[1] = e20 + e02;
				d[2] = e12 + e21;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1 <= sel;
			bad_s1 <= arg[AW-1] || (arg == '0);
			arg_s1 <= arg[AW-2:0];
			for (int k = 0; k < LANES; k++) begin
				neg_s1[k] <= d[k][17];
				mag_s1[k] <= d[k][17] ? 17'(18'sd0 - d[k]) : d[k][16:0];
			end
		end
	end

endmodule

/* rtl/rmq_sqrt.sv */
// Digit-by-digit integer square root, one result bit per pipeline stage.
module rmq_sqrt #(
	parameter int RB = 16,
	parameter int PW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [2*RB-1:0] in_n,
	input  logic [PW-1:0]   in_pay,
	output logic            out_vld,
	output logic [RB-1:0]   out_root,
	output logic [PW-1:0]   out_pay
);

	localparam int NW = 2 * RB;

	logic          vld_q  [RB];
	logic [NW-1:0] rem_q  [RB];
	logic [RB-1:0] root_q [RB];
	logic [PW-1:0] pay_q  [RB];

	for (genvar j = 0; j < RB; j++) begin : g_stage
		localparam int I = RB - 1 - j;
		logic          v_in;
		logic [NW-1:0] rem_in;
		logic [RB-1:0] root_in;
		logic [PW-1:0] pay_in;
		logic [NW:0]   trial;
		logic          take;

		if (j == 0) begin : g_first
			assign v_in    = in_vld;
			assign rem_in  = in_n;
			assign root_in = '0;
			assign pay_in  = in_pay;
		end else begin : g_next
			assign v_in    = vld_q[j-1];
			assign rem_in  = rem_q[j-1];
			assign root_in = root_q[j-1];
			assign pay_in  = pay_q[j-1];
		end

		// (2*root + 2^I) * 2^I against the running remainder
		assign trial = ((NW+1)'(root_in) << (I + 1)) + ((NW+1)'(1) << (2 * I));
		assign take  = {1'b0, rem_in} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (en) begin
				vld_q[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j]  <= take ? rem_in - trial[NW-1:0] : rem_in;
				root_q[j] <= take ? (root_in | (RB'(1) << I)) : root_in;
				pay_q[j]  <= pay_in;
			end
		end
	end

	assign out_vld  = vld_q[RB-1];
	assign out_root = root_q[RB-1];
	assign out_pay  = pay_q[RB-1];

endmodule

/* rtl/rmq_div.sv */
// Restoring divider for the three lanes: overflow check, then one quotient bit per stage.
module rmq_div import rmq_pkg::*; #(
	parameter int DW   = 17,
	parameter int NUMW = 32,
	parameter int PW   = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [NUMW-1:0] in_num [LANES],
	input  logic [DW-1:0]   in_den,
	input  logic [PW-1:0]   in_pay,
	output logic            out_vld,
	output logic [QB-1:0]   out_q [LANES],
	output logic [LANES-1:0] out_ovf,
	output logic [PW-1:0]   out_pay
);

	localparam int CW = (NUMW > DW + QB) ? NUMW : DW + QB;
	localparam int NS = QB + 1;

	logic             vld_q [NS];
	logic [NUMW-1:0]  rem_q [NS][LANES];
	logic [QB-1:0]    quo_q [NS][LANES];
	logic [LANES-1:0] ovf_q [NS];
	logic [DW-1:0]    den_q [NS];
	logic [PW-1:0]    pay_q [NS];

	// Stage 0: quotient would not fit in QB bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				rem_q[0][k] <= in_num[k];
				quo_q[0][k] <= '0;
				ovf_q[0][k] <= CW'(in_num[k]) >= (CW'(in_den) << QB);
			end
			den_q[0] <= in_den;
			pay_q[0] <= in_pay;
		end
	end

	for (genvar j = 1; j < NS; j++) begin : g_stage
		localparam int I = QB - j;
		logic [CW-1:0] step;
		logic [LANES-1:0] take;

		assign step = CW'(den_q[j-1]) << I;
		for (genvar k = 0; k < LANES; k++) begin : g_lane
			assign take[k] = CW'(rem_q[j-1][k]) >= step;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (en) begin
				vld_q[j] <= vld_q[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < LANES; k++) begin
					rem_q[j][k] <= take[k] ? rem_q[j-1][k] - step[NUMW-1:0]
						: rem_q[j-1][k];
					quo_q[j][k] <= take[k] ? (quo_q[j-1][k] | (QB'(1) << I))
						: quo_q[j-1][k];
				end
				ovf_q[j] <= ovf_q[j-1];
				den_q[j] <= den_q[j-1];
				pay_q[j] <= pay_q[j-1];
			end
		end
	end

	assign out_vld = vld_q[NS-1];
	assign out_q   = quo_q[NS-1];
	assign out_ovf = ovf_q[NS-1];
	assign out_pay = pay_q[NS-1];

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Top level: rotation matrix to quaternion, Shepperd's method, fully pipelined.
// One matrix word is taken per cycle and one quaternion word leaves per cycle while the
// output word is taken; RB = ceil((max(FRAC_BITS,17) + 1 + FRAC_BITS) / 2) is the number
// of square-root stages. The pipeline is one front stage, RB root stages (one root bit
// each), one prep stage, an overflow stage and 17 divider stages (one quotient bit
// each), and the output register. The whole pipeline holds while the output word is
// not taken; ready follows that stall.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	rmq_in_if.sink          matrix,
	rmq_out_if.source       quat
);

	localparam int MX   = (FRAC_BITS > 17) ? FRAC_BITS : 17;
	localparam int AW   = MX + 2;
	localparam int NW   = AW - 1 + FRAC_BITS;
	localparam int RB   = (NW + 1) / 2;
	localparam int DW   = RB + 1;
	localparam int NUMW = MAG_W + FRAC_BITS + 1;
	localparam int PW1  = 2 + 1 + LANES + LANES * MAG_W;
	localparam int PW2  = 2 + 1 + LANES + ENTRY_W;
	localparam logic signed [ENTRY_W-1:0] ID_W =
		(FRAC_BITS >= 15) ? COMP_MAX : ENTRY_W'(32'd1 << FRAC_BITS);

	logic en;

	// Front stage
	logic             vld_s1;
	term_t            sel_s1;
	logic             bad_s1;
	logic [AW-2:0]    arg_s1;
	logic [LANES-1:0] neg_s1;
	logic [MAG_W-1:0] mag_s1 [LANES];

	// Root pipeline
	logic [2*RB-1:0]  sq_n;
	logic [PW1-1:0]   sq_pay_in, sq_pay_out;
	logic             sq_vld;
	logic [RB-1:0]    sq_root;

	// Prep stage
	logic             vld_s2;
	logic [NUMW-1:0]  num_s2 [LANES];
	logic [DW-1:0]    den_s2;
	logic [PW2-1:0]   pay_s2;
	logic [1:0]       p_sel;
	logic             p_bad;
	logic [LANES-1:0] p_neg;
	logic [MAG_W-1:0] p_mag [LANES];
	logic [RB:0]      p_half;
	entry_t           p_half16;

	// Divider output
	logic             dv_vld;
	logic [QB-1:0]    dv_q [LANES];
	logic [LANES-1:0] dv_ovf;
	logic [PW2-1:0]   dv_pay;
	logic [1:0]       f_sel;
	logic             f_bad;
	logic [LANES-1:0] f_neg;
	entry_t           f_half;
	entry_t           f_lane [LANES];
	entry_t           f_comp [4];

	logic             out_vld_q;

	assign en           = !out_vld_q || quat.ready;
	assign matrix.ready = en;

	rmq_front #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_front (
		.clk, .arst_n, .en,
		.in_vld (matrix.valid),
		.m00 (matrix.m_0_0), .m01 (matrix.m_0_1), .m02 (matrix.m_0_2),
		.m10 (matrix.m_1_0), .m11 (matrix.m_1_1), .m12 (matrix.m_1_2),
		.m20 (matrix.m_2_0), .m21 (matrix.m_2_1), .m22 (matrix.m_2_2),
		.vld_s1, .sel_s1, .bad_s1, .arg_s1, .neg_s1, .mag_s1
	);

	// Root argument is (term + 1) << FRAC_BITS; zero when not positive
	assign sq_n      = bad_s1 ? '0 : ((2*RB)'(arg_s1) << FRAC_BITS);
	assign sq_pay_in = {sel_s1, bad_s1, neg_s1, mag_s1[0], mag_s1[1], mag_s1[2]};

	rmq_sqrt #(.RB(RB), .PW(PW1)) u_sqrt (
		.clk, .arst_n, .en,
		.in_vld   (vld_s1),
		.in_n     (sq_n),
		.in_pay   (sq_pay_in),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_pay  (sq_pay_out)
	);

	// Prep: halved root, divisor 2s, numerators (|d| << F) + s
	assign {p_sel, p_bad, p_neg, p_mag[0], p_mag[1], p_mag[2]} = sq_pay_out;
	assign p_half   = ((RB+1)'(sq_root) + (RB+1)'(1)) >> 1;
	assign p_half16 = (p_half > (RB+1)'(32767)) ? COMP_MAX : ENTRY_W'(p_half);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				num_s2[k] <= (NUMW'(p_mag[k]) << FRAC_BITS) + NUMW'(sq_root);
			end
			den_s2 <= {sq_root, 1'b0};
			pay_s2 <= {p_sel, p_bad, p_neg, p_half16};
		end
	end

	rmq_div #(.DW(DW), .NUMW(NUMW), .PW(PW2)) u_div (
		.clk, .arst_n, .en,
		.in_vld  (vld_s2),
		.in_num  (num_s2),
		.in_den  (den_s2),
		.in_pay  (pay_s2),
		.out_vld (dv_vld),
		.out_q   (dv_q),
		.out_ovf (dv_ovf),
		.out_pay (dv_pay)
	);

	// Signed saturation of each lane
	assign {f_sel, f_bad, f_neg, f_half} = dv_pay;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			if (!f_neg[k]) begin
				f_lane[k] = (dv_ovf[k] || dv_q[k] > QB'(32767)) ? COMP_MAX
					: ENTRY_W'(dv_q[k]);
			end else begin
				f_lane[k] = (dv_ovf[k] || dv_q[k] > QB'(32768)) ? COMP_MIN
					: ENTRY_W'(QB'(0) - dv_q[k]);
			end
		end
	end

	// Put the chosen component back in its slot, or the identity when the term is not positive
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (f_bad) begin
				f_comp[j] = (j == 0) ? ID_W : '0;
			end else if (j < int'(f_sel)) begin
				f_comp[j] = f_lane[(j < LANES) ? j : LANES - 1];
			end else if (j == int'(f_sel)) begin
				f_comp[j] = f_half;
			end else begin
				f_comp[j] = f_lane[(j > 0) ? j - 1 : 0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat.quat_w       <= f_comp[0];
			quat.quat_x       <= f_comp[1];
			quat.quat_y       <= f_comp[2];
			quat.quat_z       <= f_comp[3];
			quat.largest_term <= f_sel;
			quat.not_rotation <= f_bad;
		end
	end

	assign quat.valid = out_vld_q;

endmodule
